// ===== rtl/calendar_date_from_julian_day_unit_assert.svh =====
// assertion macros used by the julian day conversion rtl
// no dependencies; the including file supplies clock, reset and signals
`ifndef CALENDAR_DATE_FROM_JULIAN_DAY_UNIT_ASSERT_SVH
`define CALENDAR_DATE_FROM_JULIAN_DAY_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CDJD_ASSERT_SAME(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CDJD_ASSERT_NEXT(label, clk, rst_n, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/cdjd_pkg.sv =====
// widths, constants, types and the month start table of the julian day converter
// no dependencies
package cdjd_pkg;

    // field widths
    localparam int JD_W    = 22;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;

    // gregorian correction
    localparam logic [JD_W-1:0] GREG_FIRST_DAY = 22'd2299161;
    localparam int ALPHA_NUM_W = 24;
    localparam int ALPHA_Q_W   = 7;
    localparam int ALPHA_DIV   = 146097;
    localparam int ALPHA_W     = 6;
    // 4*1867216 + 1
    localparam logic [ALPHA_NUM_W-1:0] ALPHA_BIAS = 24'd7468865;

    // year estimate
    localparam int B_W        = 23;
    localparam int YEAR_NUM_W = 27;
    localparam int YEAR_Q_W   = 15;
    localparam int YEAR_DIV   = 7305;
    localparam int C_W        = 14;
    localparam logic [B_W-1:0]        B_OFFSET   = 23'd1524;
    localparam logic [YEAR_NUM_W-1:0] YEAR_NUM_OFS = 27'd2442;
    localparam logic [B_W-1:0]        DAYS_PER_YEAR = 23'd365;

    // month and day
    localparam int REM_W = 9;
    localparam int E_W   = 4;
    localparam logic [E_W-1:0] MONTHS   = 4'd12;
    localparam logic [E_W-1:0] FEBRUARY = 4'd2;
    localparam logic signed [YEAR_W:0] YEAR_BASE = 15'sd4715;

    typedef struct packed {
        logic mul;
        logic fix;
    } t_div_en;

    // floor(30.6001 * e), days before month index e in a march-based year
    function automatic logic [REM_W-1:0] month_start(input logic [E_W-1:0] e);
        logic [REM_W-1:0] v;
        case (e)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd30;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd91;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd183;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd244;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd336;
            4'd12:   v = 9'd367;
            4'd13:   v = 9'd397;
            4'd14:   v = 9'd428;
            default: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/cdjd_const_div.sv =====
// two-stage divider by a constant: reciprocal multiply, then one correction step
// depends on cdjd_pkg (t_div_en, default widths)
module cdjd_const_div
    import cdjd_pkg::*;
#(
    parameter int NUM_W   = ALPHA_NUM_W,
    parameter int Q_W     = ALPHA_Q_W,
    parameter int DIVISOR = ALPHA_DIV
) (
    input  logic             i_clk,
    input  t_div_en          i_en,
    input  logic [NUM_W-1:0] i_num,
    output logic [Q_W-1:0]   o_quot
);

    // floor(2^NUM_W / DIVISOR) underestimates the quotient by at most one
    localparam longint unsigned RECIP_L = (64'd1 << NUM_W) / DIVISOR;
    localparam logic [Q_W-1:0]   RECIP = Q_W'(RECIP_L);
    localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIVISOR);

    logic [NUM_W+Q_W-1:0] r_prod, n_prod;
    logic [NUM_W-1:0]     r_num;
    logic [Q_W-1:0]       r_quot, n_quot;
    logic [Q_W-1:0]       q_est;
    logic [NUM_W+Q_W-1:0] back;
    logic [NUM_W-1:0]     rem;

    assign n_prod = {{Q_W{1'b0}}, i_num} * {{NUM_W{1'b0}}, RECIP};

    always_comb begin
        q_est  = r_prod[NUM_W+Q_W-1:NUM_W];
        back   = {{NUM_W{1'b0}}, q_est} * {{Q_W{1'b0}}, DIV_N};
        rem    = r_num - back[NUM_W-1:0];
        n_quot = (rem >= DIV_N) ? q_est + Q_W'(1) : q_est;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.mul) begin
            r_prod <= n_prod;
            r_num  <= i_num;
        end
        if (i_en.fix) begin
            r_quot <= n_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

// ===== rtl/calendar_date_from_julian_day_unit.sv =====
// julian day number to calendar month, day and year, eight-stage pipeline
// depends on cdjd_pkg, cdjd_const_div and calendar_date_from_julian_day_unit_assert.svh
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  ------------------------------------
//  in       to block   i_valid / o_ready   i_julian_day[21:0]
//  out      from block o_valid / i_ready   o_month[3:0] o_day[4:0] o_year[13:0]
//
//  an accepted day passes through the stage registers in order; o_valid is the last stage's valid bit
//  one transaction per cycle sustained while i_ready stays high; the stage chain holds up to eight at once
//  synchronous active-low reset clears only the stage valid bits
//  a stalled output freezes only the stages that are full; bubbles keep filling
//  ready ripples back through the eight stage enables
`include "calendar_date_from_julian_day_unit_assert.svh"

module calendar_date_from_julian_day_unit
    import cdjd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [JD_W-1:0]          i_julian_day,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [MONTH_W-1:0]       o_month,
    output logic [DAY_W-1:0]         o_day,
    output logic signed [YEAR_W-1:0] o_year
);

    localparam int STAGES = 8;

    // stage k of the description below holds its valid bit at r_valid[k-1]
    logic [STAGES-1:0] r_valid, n_valid;
    logic [STAGES-1:0] en;

    // stage enables: a stage loads when it is empty or the one after it moves
    always_comb begin
        en[STAGES-1] = !r_valid[STAGES-1] || i_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k+1];
        end
        n_valid[0] = en[0] ? i_valid : r_valid[0];
        for (int k = 1; k < STAGES; k++) begin
            n_valid[k] = en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[STAGES-1];

    // stage 1: gregorian test and the alpha numerator 4*(J-1867216)-1
    logic [ALPHA_NUM_W-1:0] alpha_num;
    logic [JD_W-1:0]        r1_jd;
    logic                   r1_greg;

    assign alpha_num = {i_julian_day, 2'b00} - ALPHA_BIAS;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_jd   <= i_julian_day;
            r1_greg <= (i_julian_day >= GREG_FIRST_DAY);
        end
    end

    // stages 1-2: alpha = numerator / 146097 (only meaningful on gregorian days)
    // the divider registers its numerator at stage 1 alongside r1_jd
    t_div_en              alpha_en;
    logic [ALPHA_Q_W-1:0] alpha_q;

    assign alpha_en.mul = en[0];
    assign alpha_en.fix = en[1];

    cdjd_const_div #(
        .NUM_W   (ALPHA_NUM_W),
        .Q_W     (ALPHA_Q_W),
        .DIVISOR (ALPHA_DIV)
    ) u_alpha_div (
        .i_clk  (i_clk),
        .i_en   (alpha_en),
        .i_num  (alpha_num),
        .o_quot (alpha_q)
    );

    logic [JD_W-1:0] r2_jd;
    logic            r2_greg;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r2_jd   <= r1_jd;
            r2_greg <= r1_greg;
        end
    end

    // stage 3: b = a + 1524 and the year numerator 20*b - 2442
    logic [ALPHA_W-1:0]    alpha;
    logic [B_W-1:0]        a_day, b_day;
    logic [YEAR_NUM_W-1:0] year_num;
    logic [B_W-1:0]        r3_b;
    logic [YEAR_NUM_W-1:0] r3_m;

    always_comb begin
        alpha = alpha_q[ALPHA_W-1:0];
        if (r2_greg) begin
            a_day = B_W'(r2_jd) + B_W'(1) + B_W'(alpha) - B_W'(alpha >> 2);
        end else begin
            a_day = B_W'(r2_jd);
        end
        b_day    = a_day + B_OFFSET;
        // 20*b as 16*b + 4*b
        year_num = (YEAR_NUM_W'(b_day) << 4) + (YEAR_NUM_W'(b_day) << 2) - YEAR_NUM_OFS;
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r3_b <= b_day;
            r3_m <= year_num;
        end
    end

    // stages 4-5: c = year numerator / 7305
    t_div_en             year_en;
    logic [YEAR_Q_W-1:0] year_q;

    assign year_en.mul = en[3];
    assign year_en.fix = en[4];

    cdjd_const_div #(
        .NUM_W   (YEAR_NUM_W),
        .Q_W     (YEAR_Q_W),
        .DIVISOR (YEAR_DIV)
    ) u_year_div (
        .i_clk  (i_clk),
        .i_en   (year_en),
        .i_num  (r3_m),
        .o_quot (year_q)
    );

    logic [B_W-1:0] r4_b, r5_b;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r4_b <= r3_b;
        end
        if (en[4]) begin
            r5_b <= r4_b;
        end
    end

    // stage 6: days into the march-based year, rem = b - (365*c + c/4)
    logic [C_W-1:0]   c_year;
    logic [B_W-1:0]   d_days;
    logic [B_W:0]     rem_full;
    logic [REM_W-1:0] rem_days;
    logic [C_W-1:0]   r6_c;
    logic [REM_W-1:0] r6_rem;

    always_comb begin
        c_year   = year_q[C_W-1:0];
        d_days   = B_W'(c_year) * DAYS_PER_YEAR + B_W'(c_year >> 2);
        rem_full = {1'b0, r5_b} - {1'b0, d_days};
        // a negative remainder is clamped to zero
        rem_days = rem_full[B_W] ? '0 : rem_full[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r6_c   <= c_year;
            r6_rem <= rem_days;
        end
    end

    // stage 7: month index e = floor(rem / 30.6001), counted against the month starts
    logic [E_W-1:0]   e_idx;
    logic [C_W-1:0]   r7_c;
    logic [REM_W-1:0] r7_rem;
    logic [E_W-1:0]   r7_e;

    always_comb begin
        e_idx = '0;
        for (int k = 1; k < (1 << E_W); k++) begin
            e_idx = e_idx + E_W'(r6_rem > month_start(E_W'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r7_c   <= r6_c;
            r7_rem <= r6_rem;
            r7_e   <= e_idx;
        end
    end

    // stage 8: day, month with the march-based wrap, year with the bc shift
    logic [DAY_W-1:0]         day_n;
    logic [REM_W-1:0]         day_full;
    logic [E_W-1:0]           mon_raw, mon_n;
    logic signed [YEAR_W:0]   yr0, yr1, yr2;
    logic [MONTH_W-1:0]       r_month;
    logic [DAY_W-1:0]         r_day;
    logic signed [YEAR_W-1:0] r_year;

    always_comb begin
        day_full = r7_rem - month_start(r7_e);
        day_n    = day_full[DAY_W-1:0];
        mon_raw  = r7_e - E_W'(1);
        mon_n    = (mon_raw > MONTHS) ? mon_raw - MONTHS : mon_raw;
        yr0      = signed'({1'b0, r7_c}) - YEAR_BASE;
        yr1      = (mon_n > FEBRUARY) ? yr0 - (YEAR_W+1)'(1) : yr0;
        // no year zero: 0 and below shift down by one
        yr2      = (yr1 <= 0) ? yr1 - (YEAR_W+1)'(1) : yr1;
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_month <= mon_n;
            r_day   <= day_n;
            r_year  <= yr2[YEAR_W-1:0];
        end
    end

    assign o_month = r_month;
    assign o_day   = r_day;
    assign o_year  = r_year;

    `CDJD_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_valid[0], "accepted transaction missing from first stage")
    `CDJD_ASSERT_SAME(a_full_stall_blocks, i_clk, i_rst_n, (&r_valid) && !i_ready, !o_ready, "full pipeline took a transaction under output stall")
    `CDJD_ASSERT_SAME(a_date_range, i_clk, i_rst_n, o_valid, (o_month != '0) && (o_month <= MONTHS) && (o_day != '0), "month or day out of range")
    `CDJD_ASSERT_SAME(a_no_year_zero, i_clk, i_rst_n, o_valid, o_year != '0, "year zero produced")

endmodule

// ===== verif/calendar_date_from_julian_day_checker.sv =====
// scoreboard for the julian day to calendar date converter: watches both channels,
// predicts each date and compares it field by field with the block's result
// depends on cdjd_pkg for the field widths
module calendar_date_from_julian_day_checker
    import cdjd_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic [JD_W-1:0]          i_julian_day,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic [MONTH_W-1:0]       i_month,
    input  logic [DAY_W-1:0]         i_day,
    input  logic signed [YEAR_W-1:0] i_year,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    localparam longint GREGORIAN_START = 2299161;
    localparam int     REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [JD_W-1:0]          jd;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic signed [YEAR_W-1:0] year;
    } t_cal_date;

    t_cal_date pending_dates[$];

    int fail_count    = 0;
    int pending_count = 0;
    int checked_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;
    assign o_checked    = checked_count;

    // exact integer form of the classic inverse conversion
    function automatic t_cal_date date_of_day(input logic [JD_W-1:0] jd);
        longint    j, alpha, a, b, c, d, rem, e, dom, mon, yr;
        t_cal_date r;
        j = jd;
        if (j >= GREGORIAN_START) begin
            alpha = (4 * (j - 1867216) - 1) / 146097;
            a     = j + 1 + alpha - alpha / 4;
        end else begin
            a = j;
        end
        b   = a + 1524;
        c   = (20 * b - 2442) / 7305;
        d   = 365 * c + c / 4;
        rem = b - d;
        if (rem < 0) begin
            rem = 0;
        end
        e   = (rem * 10000) / 306001;
        dom = rem - (306001 * e) / 10000;
        mon = e - 1;
        if (mon > 12) begin
            mon = mon - 12;
        end
        yr = c - 4715;
        if (mon > 2) begin
            yr = yr - 1;
        end
        // no year zero
        if (yr <= 0) begin
            yr = yr - 1;
        end
        r.jd    = jd;
        r.month = mon[MONTH_W-1:0];
        r.day   = dom[DAY_W-1:0];
        r.year  = yr[YEAR_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_cal_date want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                pending_dates.push_back(date_of_day(i_julian_day));
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_dates.size() == 0) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("unexpected result %0d/%0d/%0d with nothing pending",
                                 i_month, i_day, i_year);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = pending_dates.pop_front();
                    if (i_month !== want.month || i_day !== want.day
                            || i_year !== want.year) begin
                        if (fail_count < REPORT_LIMIT) begin
                            $display("day %0d: expected m=%0d d=%0d y=%0d, got m=%0d d=%0d y=%0d",
                                     want.jd, want.month, want.day, want.year,
                                     i_month, i_day, i_year);
                        end
                        fail_count <= fail_count + 1;
                    end
                    checked_count <= checked_count + 1;
                end
            end
            pending_count <= pending_dates.size();
        end
    end

endmodule

// ===== verif/calendar_date_from_julian_day_unit_tb.sv =====
// testbench top for calendar_date_from_julian_day_unit: directed and random julian days
// with random stalls on both channels, checked by calendar_date_from_julian_day_checker
// depends on cdjd_pkg, the block and the checker
module calendar_date_from_julian_day_unit_tb
    import cdjd_pkg::*;
();

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RESET_CYCLES = 11;
    localparam int IDLE_PCT     = 22;
    localparam int DRAIN_CYCLES = 16;   // eight pipeline stages, doubled
    localparam int RANDOM_ITEMS = 550;
    localparam int GREG_START   = 2299161;
    localparam int ALPHA_BASE   = 1867216;
    localparam int JD_MAX       = 4194303;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_valid      = 1'b0;
    logic [JD_W-1:0]          i_julian_day = '0;
    logic                     i_ready      = 1'b0;
    logic                     o_ready;
    logic                     o_valid;
    logic [MONTH_W-1:0]       o_month;
    logic [DAY_W-1:0]         o_day;
    logic signed [YEAR_W-1:0] o_year;

    int  fail_count;
    int  pending_count;
    int  checked_count;
    int  cycle_count = 0;
    int  sent_count  = 0;
    int  greg_count  = 0;
    // when set, neither side idles
    logic steady = 1'b0;

    calendar_date_from_julian_day_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_julian_day (i_julian_day),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_year       (o_year)
    );

    calendar_date_from_julian_day_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_julian_day (i_julian_day),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_month      (o_month),
        .i_day        (o_day),
        .i_year       (o_year),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    // period of two time units
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver backpressure, changed at the falling edge
    always @(negedge i_clk) begin
        if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // one input transaction; called and returns at a falling edge
    task automatic send_day(input logic [JD_W-1:0] jd);
        // random idle cycles before the transaction, valid low meanwhile
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_julian_day <= jd;
        // hold until the block takes it
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sent_count = sent_count + 1;
        if (jd >= GREG_START) begin
            greg_count = greg_count + 1;
        end
        @(negedge i_clk);
    endtask

    // hold off until every expected date has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
    endtask

    // random day, biased toward the places where the arithmetic turns
    function automatic logic [JD_W-1:0] pick_day();
        int sel;
        int m;
        int v;
        sel = $urandom_range(99);
        if (sel < 55) begin
            v = $urandom_range(JD_MAX);
        end else if (sel < 70) begin
            // around the calendar switch
            v = GREG_START - 1000 + $urandom_range(2000);
        end else if (sel < 82) begin
            // around the step from 1 bc to 1 ad
            v = 1721424 - 800 + $urandom_range(1600);
        end else if (sel < 94) begin
            // where the gregorian century correction steps
            m = $urandom_range(63, 3);
            v = ALPHA_BASE + (146097 * m) / 4 - 3 + $urandom_range(6);
        end else begin
            // near both ends of the input range
            v = ($urandom_range(1) == 1) ? JD_MAX - $urandom_range(800)
                                         : $urandom_range(800);
        end
        if (v > JD_MAX) begin
            v = JD_MAX;
        end
        if (v < 0) begin
            v = 0;
        end
        return v[JD_W-1:0];
    endfunction

    initial begin
        // synchronous reset held for a fixed count, once
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed days: range ends, calendar switch, no year zero, leap days
        send_day(22'd0);          // 1 jan 4713 bc
        send_day(22'd4194303);    // top of the input range
        send_day(22'd2299159);
        send_day(22'd2299160);    // last julian-calendar day
        send_day(22'd2299161);    // first gregorian day
        send_day(22'd2299162);
        send_day(22'd1721423);    // 31 dec 1 bc
        send_day(22'd1721424);    // 1 jan 1 ad
        send_day(22'd1721117);    // around end of february, 1 bc
        send_day(22'd1721118);
        send_day(22'd2415079);    // 28 feb 1900, not a leap year
        send_day(22'd2415080);
        send_day(22'd2451604);    // 29 feb 2000
        send_day(22'd2451605);
        send_day(22'd2451545);
        send_day(22'd1867216);
        send_day(22'd1867217);
        send_day(22'h155555);
        send_day(22'h2AAAAA);
        send_day(22'h200000);
        send_day(22'h1FFFFF);
        send_day(22'd1);

        // sender waits for the pipeline to drain
        wait_drained();

        // random part: stalls, then a stretch with no idling, then stalls again
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 200) begin
                steady <= 1'b1;
            end
            if (n == 350) begin
                steady <= 1'b0;
            end
            send_day(pick_day());
        end
        i_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d julian days converted, %0d dates checked, %0d of them gregorian",
                 sent_count, checked_count, greg_count);
        $display("span covered: both input extremes, calendar switch, 1 bc to 1 ad, leap days");
        if (fail_count == 0 && pending_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", fail_count, pending_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/cdjd_pkg.sv
rtl/cdjd_const_div.sv
rtl/calendar_date_from_julian_day_unit.sv
verif/calendar_date_from_julian_day_checker.sv
verif/calendar_date_from_julian_day_unit_tb.sv
